### hdl/assert_macros.svh
// Assertion macros shared by the RTL files of this project.
// Synthesis builds see the empty forms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge out of reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

### hdl/dbd_pkg.sv
package dbd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int COUNT_W  = 22;
	// Serial day numbers reach about 6.0 million for the widest year field.
	localparam int SERIAL_W = 23;
	localparam int QUO_W    = 8;
	localparam int REM_W    = 7;
	localparam int MUL_A_W  = 14;
	localparam int MUL_B_W  = 13;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	// floor(x / 100) == (x * 5243) >> 19 for every x below 43699.
	localparam logic [MUL_B_W-1:0] RECIP100 = 13'd5243;
	localparam int                 RECIP_SH = 19;
	localparam logic [MUL_B_W-1:0] DAYS_YEAR = 13'd365;
	localparam logic [MUL_B_W-1:0] HUNDRED   = 13'd100;

	// Steps of the shared multiply/accumulate unit, one date at a time.
	localparam logic [2:0] STEP_QUO  = 3'd0;
	localparam logic [2:0] STEP_YEAR = 3'd1;
	localparam logic [2:0] STEP_REM  = 3'd2;
	localparam logic [2:0] STEP_C4   = 3'd3;
	localparam logic [2:0] STEP_C100 = 3'd4;
	localparam logic [2:0] STEP_C400 = 3'd5;
	localparam logic [2:0] STEP_MON  = 3'd6;
	localparam logic [2:0] STEP_DAY  = 3'd7;

	typedef struct packed {
		logic       run;
		logic [2:0] step;
	} ctrl_t;

	typedef struct packed {
		logic leap;
	} stat_t;

	// Days in a month; February follows the leap flag, bad months give zero.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	// Days of the months before month m in a common year.
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

### hdl/dbd_datapath.sv
// Shared multiplier and accumulator that build one serial day number over
// eight steps.
module dbd_datapath (
	input  logic                         clk,
	input  dbd_pkg::ctrl_t               ctrl,
	input  logic [dbd_pkg::DAY_W-1:0]    day,
	input  logic [dbd_pkg::MONTH_W-1:0]  month,
	input  logic [dbd_pkg::YEAR_W-1:0]   year,
	output logic [dbd_pkg::SERIAL_W-1:0] serial,
	output dbd_pkg::stat_t               stat
);

	logic [dbd_pkg::SERIAL_W-1:0] acc_q;
	logic [dbd_pkg::QUO_W-1:0]    quo_q;
	logic [dbd_pkg::REM_W-1:0]    rem_q;

	logic [dbd_pkg::MUL_A_W-1:0]  mul_a;
	logic [dbd_pkg::MUL_B_W-1:0]  mul_b;
	logic [dbd_pkg::PROD_W-1:0]   prod;
	logic [dbd_pkg::SERIAL_W-1:0] addend;
	logic                         sub;
	logic [12:0]                  ceil4;
	logic [dbd_pkg::QUO_W-1:0]    ceil100;
	logic [5:0]                   ceil400;
	logic                         leap;

	always_comb begin
		mul_a = year;
		mul_b = dbd_pkg::DAYS_YEAR;
		case (ctrl.step)
			dbd_pkg::STEP_QUO: mul_b = dbd_pkg::RECIP100;
			dbd_pkg::STEP_REM: begin
				mul_a = dbd_pkg::MUL_A_W'(quo_q);
				mul_b = dbd_pkg::HUNDRED;
			end
			default: ;
		endcase
	end

	assign prod = dbd_pkg::PROD_W'(mul_a) * dbd_pkg::PROD_W'(mul_b);

	// Ceilings of year/4, year/100 and year/400; the last nests on the second.
	assign ceil4   = 13'(year >> 2) + 13'(|year[1:0]);
	assign ceil100 = quo_q + dbd_pkg::QUO_W'(rem_q != '0);
	assign ceil400 = 6'(ceil100 >> 2) + 6'(|ceil100[1:0]);
	assign leap    = (year[1:0] == 2'd0) && ((rem_q != '0) || (quo_q[1:0] == 2'd0));

	always_comb begin
		addend = '0;
		sub    = 1'b0;
		case (ctrl.step)
			dbd_pkg::STEP_C4:   addend = dbd_pkg::SERIAL_W'(ceil4);
			dbd_pkg::STEP_C100: begin
				addend = dbd_pkg::SERIAL_W'(ceil100);
				sub    = 1'b1;
			end
			dbd_pkg::STEP_C400: addend = dbd_pkg::SERIAL_W'(ceil400);
			dbd_pkg::STEP_MON:  addend = dbd_pkg::SERIAL_W'(dbd_pkg::cum_days(month))
				+ dbd_pkg::SERIAL_W'(leap && (month > 4'd2));
			dbd_pkg::STEP_DAY:  addend = dbd_pkg::SERIAL_W'(day);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			case (ctrl.step)
				dbd_pkg::STEP_QUO:  quo_q <= prod[dbd_pkg::RECIP_SH +: dbd_pkg::QUO_W];
				dbd_pkg::STEP_YEAR: acc_q <= prod[dbd_pkg::SERIAL_W-1:0];
				dbd_pkg::STEP_REM:  rem_q <= dbd_pkg::REM_W'(year - prod[dbd_pkg::YEAR_W-1:0]);
				default: begin
					acc_q <= sub ? acc_q - addend : acc_q + addend;
				end
			endcase
		end
	end

	assign serial    = acc_q;
	assign stat.leap = leap;

endmodule

### hdl/days_between_dates_top.sv
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid / in_ready  first_day, first_month, first_year,
//                                          second_day, second_month, second_year
// out      output     out_valid/out_ready  day_count, date_invalid
//
// Each input beat goes from acceptance to a result in the output register
// through 8 steps of the shared multiply/accumulate unit per date and the
// magnitude of the difference. in_ready is high only when the
// sequencer is idle. A held output beat does not block the next input beat;
// the sequencer waits in its final state only if a new result is ready while
// the previous one is still held. arst_n clears the sequencer and output valid.
`include "assert_macros.svh"

module days_between_dates_top #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dbd_pkg::DAY_W-1:0]    first_day,
	input  logic [dbd_pkg::MONTH_W-1:0]  first_month,
	input  logic [dbd_pkg::YEAR_W-1:0]   first_year,
	input  logic [dbd_pkg::DAY_W-1:0]    second_day,
	input  logic [dbd_pkg::MONTH_W-1:0]  second_month,
	input  logic [dbd_pkg::YEAR_W-1:0]   second_year,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dbd_pkg::COUNT_W-1:0]  day_count,
	output logic                         date_invalid
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [2:0] step_q;
	logic       sel_q;
	logic       bad_q;
	logic       out_valid_q;

	// Captured input beat.
	logic [dbd_pkg::DAY_W-1:0]    d1_q, d2_q;
	logic [dbd_pkg::MONTH_W-1:0]  m1_q, m2_q;
	logic [dbd_pkg::YEAR_W-1:0]   y1_q, y2_q;
	logic [dbd_pkg::SERIAL_W-1:0] first_serial_q;
	logic [dbd_pkg::COUNT_W-1:0]  count_q;
	logic                         invalid_q;

	logic [dbd_pkg::DAY_W-1:0]    cur_day;
	logic [dbd_pkg::MONTH_W-1:0]  cur_month;
	logic [dbd_pkg::YEAR_W-1:0]   cur_year;
	logic [dbd_pkg::SERIAL_W-1:0] serial;
	logic [dbd_pkg::SERIAL_W-1:0] diff;
	dbd_pkg::ctrl_t               ctrl;
	dbd_pkg::stat_t               stat;
	logic                         cur_bad;
	logic                         in_fire;
	logic                         out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// The unit works on the first date, then the second.
	assign cur_day   = sel_q ? d2_q : d1_q;
	assign cur_month = sel_q ? m2_q : m1_q;
	assign cur_year  = sel_q ? y2_q : y1_q;

	assign ctrl.run  = (state_q == ST_RUN);
	assign ctrl.step = step_q;

	dbd_datapath u_datapath (
		.clk    (clk),
		.ctrl   (ctrl),
		.day    (cur_day),
		.month  (cur_month),
		.year   (cur_year),
		.serial (serial),
		.stat   (stat)
	);

	// A date fails on a zero day, a bad month, a year past the limit, or a day
	// past the end of its month. The leap flag is settled by the month step.
	assign cur_bad = (cur_day == '0) || (cur_month == '0) || (cur_month > 4'd12)
		|| (32'(cur_year) > MAX_YEAR)
		|| (cur_day > dbd_pkg::month_len(cur_month, stat.leap));

	// While done, the accumulator holds the second serial day number.
	assign diff = (first_serial_q > serial) ? first_serial_q - serial
		: serial - first_serial_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= dbd_pkg::STEP_QUO;
			sel_q       <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace a beat that leaves at this same edge.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						step_q  <= dbd_pkg::STEP_QUO;
						sel_q   <= 1'b0;
						bad_q   <= 1'b0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == dbd_pkg::STEP_MON && cur_bad) begin
						bad_q <= 1'b1;
					end
					if (step_q == dbd_pkg::STEP_DAY) begin
						sel_q <= 1'b1;
						if (sel_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			d1_q <= first_day;
			m1_q <= first_month;
			y1_q <= first_year;
			d2_q <= second_day;
			m2_q <= second_month;
			y2_q <= second_year;
		end
		// The first serial number is still in the accumulator when the second
		// date starts its first step.
		if (state_q == ST_RUN && sel_q && step_q == dbd_pkg::STEP_QUO) begin
			first_serial_q <= serial;
		end
		if (state_q == ST_DONE && out_free) begin
			count_q   <= bad_q ? '0 : diff[dbd_pkg::COUNT_W-1:0];
			invalid_q <= bad_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign day_count    = count_q;
	assign date_invalid = invalid_q;

	`ASSERT_AT(a_invalid_zero, clk, arst_n, (out_valid && date_invalid) |-> (day_count == '0), "invalid beat with nonzero count")
	`ASSERT_AT(a_accept_runs, clk, arst_n, in_fire |=> (state_q == ST_RUN), "accepted beat did not start the sequencer")
	`ASSERT_AT(a_rise_from_done, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "output raised outside the final state")
	`ASSERT_AT(a_hold_done, clk, arst_n, (state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE), "result overwrote a held beat")

endmodule
